@@ rtl/core/bps_pkg.sv @@
package bps_pkg;

  // Default width of the tick counters
  localparam int TICK_COUNT_BITS = 16;

  // Field widths
  localparam int ACTION_W    = 2;
  localparam int TICKS_W     = 16;
  localparam int COUNT_W     = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Input actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_t;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_PENDING = 3'd0,
    PH_BEEP    = 3'd1,
    PH_GAP     = 3'd2,
    PH_COUNT   = 3'd3,
    PH_PAUSE   = 3'd4,
    PH_PLAYS   = 3'd5,
    PH_IDLE    = 3'd7
  } phase_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TONE0_BEEP_TICKS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TONE0_GAP_TICKS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TONE0_BEEP_COUNT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TONE1_BEEP_TICKS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TONE1_GAP_TICKS  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TONE1_BEEP_COUNT = 3'd5;

  // Reset beep counts
  localparam logic [COUNT_W-1:0] TONE0_COUNT_RESET = 8'd3;
  localparam logic [COUNT_W-1:0] TONE1_COUNT_RESET = 8'd1;

  // Settings of one tone type
  typedef struct packed {
    logic [TICKS_W-1:0] beep_ticks;
    logic [TICKS_W-1:0] gap_ticks;
    logic [COUNT_W-1:0] beep_count;
  } tone_cfg_t;

endpackage

@@ rtl/core/bps_cfg_regs.sv @@
module bps_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]   cfg_data,
  output bps_pkg::tone_cfg_t               tone0,
  output bps_pkg::tone_cfg_t               tone1
);

  // Always ready: every write is accepted and registered
  assign cfg_ready = 1'b1;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      tone0.beep_ticks <= '0;
      tone0.gap_ticks  <= '0;
      tone0.beep_count <= bps_pkg::TONE0_COUNT_RESET;
      tone1.beep_ticks <= '0;
      tone1.gap_ticks  <= '0;
      tone1.beep_count <= bps_pkg::TONE1_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bps_pkg::CFG_TONE0_BEEP_TICKS: tone0.beep_ticks <= cfg_data;
        bps_pkg::CFG_TONE0_GAP_TICKS:  tone0.gap_ticks  <= cfg_data;
        bps_pkg::CFG_TONE0_BEEP_COUNT: tone0.beep_count <= cfg_data[bps_pkg::COUNT_W-1:0];
        bps_pkg::CFG_TONE1_BEEP_TICKS: tone1.beep_ticks <= cfg_data;
        bps_pkg::CFG_TONE1_GAP_TICKS:  tone1.gap_ticks  <= cfg_data;
        bps_pkg::CFG_TONE1_BEEP_COUNT: tone1.beep_count <= cfg_data[bps_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/beep_pattern_sequencer.sv @@
// Buzzer pattern sequencer driven by ticks.
// Input channel (in_valid / in_stall): action (tick, start, stop), plus
// tone_select, play_count and pause_ticks, which only a start uses.
// Output channel (out_valid / out_stall): one transaction per input
// transaction, carrying buzzer_on and busy_res after that item's update.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data):
// per-tone beep on-time, gap and beep count; always ready. The user must
// write it only while idle; the block itself does not enforce this.
// The result is registered; it is valid in the cycle after input acceptance.
// Throughput: one item per cycle unless stalled; the counters update in one
// pass of logic between the state registers and the single result register.
// When the receiver stalls, the result register holds its transaction and
// in_stall rises only while that register is full and stalled, so a new
// item enters in the same cycle the old result leaves.
// Reset: idle phase, tone off, all counters zero, output empty, beep
// counts 3 (tone 0) and 1 (tone 1), all tick settings zero.
module beep_pattern_sequencer #(
  parameter int TICK_COUNT_BITS = bps_pkg::TICK_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bps_pkg::ACTION_W-1:0]     action,
  input  logic                             tone_select,
  input  logic [bps_pkg::TICKS_W-1:0]      play_count,
  input  logic [bps_pkg::TICKS_W-1:0]      pause_ticks,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             buzzer_on,
  output logic                             busy_res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int TW = TICK_COUNT_BITS;

  bps_pkg::tone_cfg_t tone0;
  bps_pkg::tone_cfg_t tone1;
  bps_pkg::tone_cfg_t tone_sel;

  bps_pkg::phase_t phase, phase_next;
  logic [TW-1:0] beep_left, beep_left_next;
  logic [TW-1:0] gap_left, gap_left_next;
  logic [bps_pkg::COUNT_W-1:0] beeps_left, beeps_left_next;
  logic [TW-1:0] pause_left, pause_left_next;
  logic [TW-1:0] plays_left, plays_left_next;
  logic [bps_pkg::TICKS_W-1:0] pause_reload, pause_reload_next;
  logic [bps_pkg::TICKS_W-1:0] plays_reload, plays_reload_next;
  logic tone_latched, tone_latched_next;
  logic tone_enable, tone_enable_next;

  logic [TW-1:0] beep_dec, gap_dec, pause_dec, plays_dec;
  logic [bps_pkg::COUNT_W-1:0] beeps_dec;
  logic in_accept;

  bps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tone0     (tone0),
    .tone1     (tone1)
  );

  // Stall only while the result register is full and held
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign tone_sel = tone_latched ? tone1 : tone0;

  // Saturating decrements
  assign beep_dec  = (beep_left  != '0) ? beep_left  - 1'b1 : '0;
  assign gap_dec   = (gap_left   != '0) ? gap_left   - 1'b1 : '0;
  assign beeps_dec = (beeps_left != '0) ? beeps_left - 1'b1 : '0;
  assign pause_dec = (pause_left != '0) ? pause_left - 1'b1 : '0;
  assign plays_dec = (plays_left != '0) ? plays_left - 1'b1 : '0;

  // Next state for the accepted item
  always_comb begin
    phase_next        = phase;
    beep_left_next    = beep_left;
    gap_left_next     = gap_left;
    beeps_left_next   = beeps_left;
    pause_left_next   = pause_left;
    plays_left_next   = plays_left;
    pause_reload_next = pause_reload;
    plays_reload_next = plays_reload;
    tone_latched_next = tone_latched;
    tone_enable_next  = tone_enable;
    if (in_accept) begin
      case (bps_pkg::action_t'(action))
        bps_pkg::ACT_TICK: begin
          case (phase)
            bps_pkg::PH_PENDING: begin
              beep_left_next   = TW'(tone_sel.beep_ticks);
              gap_left_next    = TW'(tone_sel.gap_ticks);
              beeps_left_next  = tone_sel.beep_count;
              pause_left_next  = TW'(pause_reload);
              plays_left_next  = TW'(plays_reload);
              tone_enable_next = 1'b1;
              phase_next       = bps_pkg::PH_BEEP;
            end
            bps_pkg::PH_BEEP: begin
              beep_left_next = beep_dec;
              if (beep_dec == '0) begin
                tone_enable_next = 1'b0;
                phase_next       = bps_pkg::PH_GAP;
              end
            end
            bps_pkg::PH_GAP: begin
              gap_left_next = gap_dec;
              if (gap_dec == '0) begin
                tone_enable_next = 1'b0;
                phase_next       = bps_pkg::PH_COUNT;
              end
            end
            bps_pkg::PH_COUNT: begin
              beeps_left_next = beeps_dec;
              if (beeps_dec != '0) begin
                beep_left_next   = TW'(tone_sel.beep_ticks);
                gap_left_next    = TW'(tone_sel.gap_ticks);
                tone_enable_next = 1'b1;
                phase_next       = bps_pkg::PH_BEEP;
              end else begin
                phase_next = bps_pkg::PH_PAUSE;
              end
            end
            bps_pkg::PH_PAUSE: begin
              pause_left_next = pause_dec;
              if (pause_dec == '0) begin
                phase_next = bps_pkg::PH_PLAYS;
              end
            end
            bps_pkg::PH_PLAYS: begin
              plays_left_next = plays_dec;
              if (plays_dec != '0) begin
                beep_left_next   = TW'(tone_sel.beep_ticks);
                gap_left_next    = TW'(tone_sel.gap_ticks);
                beeps_left_next  = tone_sel.beep_count;
                pause_left_next  = TW'(pause_reload);
                tone_enable_next = 1'b1;
                phase_next       = bps_pkg::PH_BEEP;
              end else begin
                tone_enable_next = 1'b0;
                phase_next       = bps_pkg::PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        bps_pkg::ACT_START: begin
          tone_latched_next = tone_select;
          plays_reload_next = play_count;
          pause_reload_next = pause_ticks;
          phase_next        = bps_pkg::PH_PENDING;
        end
        bps_pkg::ACT_STOP: begin
          tone_enable_next = 1'b0;
          phase_next       = bps_pkg::PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= bps_pkg::PH_IDLE;
      beep_left    <= '0;
      gap_left     <= '0;
      beeps_left   <= '0;
      pause_left   <= '0;
      plays_left   <= '0;
      pause_reload <= '0;
      plays_reload <= '0;
      tone_latched <= 1'b0;
      tone_enable  <= 1'b0;
    end else begin
      phase        <= phase_next;
      beep_left    <= beep_left_next;
      gap_left     <= gap_left_next;
      beeps_left   <= beeps_left_next;
      pause_left   <= pause_left_next;
      plays_left   <= plays_left_next;
      pause_reload <= pause_reload_next;
      plays_reload <= plays_reload_next;
      tone_latched <= tone_latched_next;
      tone_enable  <= tone_enable_next;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      buzzer_on <= tone_enable_next;
      busy_res  <= (phase_next != bps_pkg::PH_IDLE);
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import bps_pkg::*;

  // Action code that the sequencer ignores
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  // Register index outside the tone settings
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_UNUSED = 3'd7;
  localparam logic [TICKS_W-1:0] TICK_MASK = TICKS_W'((64'd1 << TICK_COUNT_BITS) - 1);

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                tone;
    logic [TICKS_W-1:0]  plays;
    logic [TICKS_W-1:0]  pause;
  } cmd_t;

  typedef struct packed {
    logic buzzer;
    logic busy;
  } flags_t;

  typedef struct {
    phase_t             phase;
    logic [TICKS_W-1:0] beep_left;
    logic [TICKS_W-1:0] gap_left;
    logic [COUNT_W-1:0] beeps_left;
    logic [TICKS_W-1:0] pause_left;
    logic [TICKS_W-1:0] plays_left;
    logic [TICKS_W-1:0] pause_reload;
    logic [TICKS_W-1:0] plays_reload;
    logic               tone_latched;
    logic               tone_enable;
  } seq_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [ACTION_W-1:0]    action = ACT_TICK;
  logic                   tone_select = 1'b0;
  logic [TICKS_W-1:0]     play_count = '0;
  logic [TICKS_W-1:0]     pause_ticks = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   buzzer_on;
  logic                   busy_res;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  beep_pattern_sequencer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .tone_select (tone_select),
    .play_count  (play_count),
    .pause_ticks (pause_ticks),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .buzzer_on   (buzzer_on),
    .busy_res    (busy_res),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted sequencer state and tone settings
  seq_state_t seq;
  tone_cfg_t  tone_set [2];

  cmd_t   cmd_q [$];
  flags_t expected_flags [$];
  cmd_t   cur_cmd;
  flags_t want;
  int     items_queued = 0;
  int     results_seen = 0;
  int     fail_cnt = 0;

  // Reload the beep on-time and gap of the latched tone
  function automatic void load_beep();
    seq.beep_left = tone_set[seq.tone_latched].beep_ticks & TICK_MASK;
    seq.gap_left  = tone_set[seq.tone_latched].gap_ticks & TICK_MASK;
  endfunction

  function automatic void load_pattern();
    load_beep();
    seq.beeps_left = tone_set[seq.tone_latched].beep_count;
    seq.pause_left = seq.pause_reload & TICK_MASK;
  endfunction

  // Apply one transaction to the predicted state and return the flags after it
  function automatic flags_t advance_sequencer(input cmd_t c);
    flags_t f;
    if (c.action == ACT_TICK) begin
      case (seq.phase)
        PH_PENDING: begin
          load_pattern();
          seq.plays_left  = seq.plays_reload & TICK_MASK;
          seq.tone_enable = 1'b1;
          seq.phase       = PH_BEEP;
        end
        PH_BEEP: begin
          if (seq.beep_left != 0) seq.beep_left = seq.beep_left - 1'b1;
          if (seq.beep_left == 0) begin
            seq.tone_enable = 1'b0;
            seq.phase       = PH_GAP;
          end
        end
        PH_GAP: begin
          if (seq.gap_left != 0) seq.gap_left = seq.gap_left - 1'b1;
          if (seq.gap_left == 0) begin
            seq.tone_enable = 1'b0;
            seq.phase       = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (seq.beeps_left != 0) seq.beeps_left = seq.beeps_left - 1'b1;
          if (seq.beeps_left != 0) begin
            load_beep();
            seq.tone_enable = 1'b1;
            seq.phase       = PH_BEEP;
          end else begin
            seq.phase = PH_PAUSE;
          end
        end
        PH_PAUSE: begin
          if (seq.pause_left != 0) seq.pause_left = seq.pause_left - 1'b1;
          if (seq.pause_left == 0) seq.phase = PH_PLAYS;
        end
        PH_PLAYS: begin
          if (seq.plays_left != 0) seq.plays_left = seq.plays_left - 1'b1;
          if (seq.plays_left != 0) begin
            load_pattern();
            seq.tone_enable = 1'b1;
            seq.phase       = PH_BEEP;
          end else begin
            seq.tone_enable = 1'b0;
            seq.phase       = PH_IDLE;
          end
        end
        default: ;
      endcase
    end else if (c.action == ACT_START) begin
      seq.tone_latched = c.tone;
      seq.plays_reload = c.plays;
      seq.pause_reload = c.pause;
      seq.phase        = PH_PENDING;
    end else if (c.action == ACT_STOP) begin
      seq.tone_enable = 1'b0;
      seq.phase       = PH_IDLE;
    end
    f.buzzer = seq.tone_enable;
    f.busy   = (seq.phase != PH_IDLE);
    return f;
  endfunction

  // Driver: bursts of transactions with random gaps between them
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_flags.push_back(advance_sequencer(cur_cmd));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          in_valid    <= 1'b1;
          action      <= cur_cmd.action;
          tone_select <= cur_cmd.tone;
          play_count  <= cur_cmd.plays;
          pause_ticks <= cur_cmd.pause;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random pattern per segment, plus one long hold-off
  int seg_left = 0;
  int stall_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 250) begin
      hold_done = 1'b1;
      hold_left = 150;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left   = $urandom_range(5, 60);
        stall_mode = $urandom_range(0, 3);
      end else begin
        seg_left = seg_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 9) < 3);
        2:       out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_flags.size() == 0) begin
        $error("unexpected result: buzzer_on=%0b busy_res=%0b", buzzer_on, busy_res);
        fail_cnt++;
      end else begin
        want = expected_flags.pop_front();
        if (buzzer_on !== want.buzzer) begin
          $error("buzzer_on mismatch: expected %0b, actual %0b", want.buzzer, buzzer_on);
          fail_cnt++;
        end
        if (busy_res !== want.busy) begin
          $error("busy_res mismatch: expected %0b, actual %0b", want.busy, busy_res);
          fail_cnt++;
        end
      end
    end
  end

  task automatic queue_cmd(input logic [ACTION_W-1:0] act, input logic tone,
                           input logic [TICKS_W-1:0] plays, input logic [TICKS_W-1:0] pause);
    cmd_t c;
    c.action = act;
    c.tone   = tone;
    c.plays  = plays;
    c.pause  = pause;
    cmd_q.push_back(c);
    items_queued++;
  endtask

  // Random transaction; start fields mostly small so patterns finish
  task automatic queue_random(input logic [ACTION_W-1:0] act);
    logic [TICKS_W-1:0] plays;
    logic [TICKS_W-1:0] pause;
    if (act == ACT_START) begin
      plays = ($urandom_range(0, 9) == 0) ? TICKS_W'($urandom) : TICKS_W'($urandom_range(0, 4));
      pause = ($urandom_range(0, 9) == 0) ? TICKS_W'($urandom) : TICKS_W'($urandom_range(0, 5));
    end else begin
      plays = TICKS_W'($urandom);
      pause = TICKS_W'($urandom);
    end
    queue_cmd(act, 1'($urandom_range(0, 1)), plays, pause);
  endtask

  // Mostly a start followed by a run of ticks; sometimes plain noise
  task automatic queue_scenario();
    int kind;
    int n;
    int r;
    logic [ACTION_W-1:0] act;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(3, 12);
      repeat (n) begin
        act = ACTION_W'($urandom_range(0, 3));
        queue_random(act);
      end
    end else begin
      queue_random(ACT_START);
      n = $urandom_range(4, 60);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 3)      queue_random(ACT_STOP);
        else if (r < 6) queue_random(ACT_START);
        else if (r < 8) queue_random(ACT_UNUSED);
        else            queue_random(ACT_TICK);
      end
      if (kind == 1) queue_random(ACT_STOP);
    end
  endtask

  task automatic run_traffic(input int n);
    int target;
    target = items_queued + n;
    while (items_queued < target) queue_scenario();
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TONE0_BEEP_TICKS: tone_set[0].beep_ticks = data;
      CFG_TONE0_GAP_TICKS:  tone_set[0].gap_ticks  = data;
      CFG_TONE0_BEEP_COUNT: tone_set[0].beep_count = data[COUNT_W-1:0];
      CFG_TONE1_BEEP_TICKS: tone_set[1].beep_ticks = data;
      CFG_TONE1_GAP_TICKS:  tone_set[1].gap_ticks  = data;
      CFG_TONE1_BEEP_COUNT: tone_set[1].beep_count = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_tones(input logic [CFG_DATA_W-1:0] b0, input logic [CFG_DATA_W-1:0] g0,
                               input logic [CFG_DATA_W-1:0] c0, input logic [CFG_DATA_W-1:0] b1,
                               input logic [CFG_DATA_W-1:0] g1, input logic [CFG_DATA_W-1:0] c1);
    write_reg(CFG_TONE0_BEEP_TICKS, b0);
    write_reg(CFG_TONE0_GAP_TICKS, g0);
    write_reg(CFG_TONE0_BEEP_COUNT, c0);
    write_reg(CFG_TONE1_BEEP_TICKS, b1);
    write_reg(CFG_TONE1_GAP_TICKS, g1);
    write_reg(CFG_TONE1_BEEP_COUNT, c1);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every transaction has gone through and the result path is empty
  task automatic settle();
    while (cmd_q.size() != 0 || in_valid || expected_flags.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    seq.phase        = PH_IDLE;
    seq.beep_left    = '0;
    seq.gap_left     = '0;
    seq.beeps_left   = '0;
    seq.pause_left   = '0;
    seq.plays_left   = '0;
    seq.pause_reload = '0;
    seq.plays_reload = '0;
    seq.tone_latched = 1'b0;
    seq.tone_enable  = 1'b0;
    tone_set[0] = '{beep_ticks: '0, gap_ticks: '0, beep_count: TONE0_COUNT_RESET};
    tone_set[1] = '{beep_ticks: '0, gap_ticks: '0, beep_count: TONE1_COUNT_RESET};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle cases, zero lengths under reset settings, restart, stop
    queue_cmd(ACT_TICK, 1'b1, 16'hffff, 16'hffff);
    queue_cmd(ACT_STOP, 1'b0, 16'h0000, 16'h0000);
    queue_cmd(ACT_UNUSED, 1'b1, 16'h5a5a, 16'ha5a5);
    queue_cmd(ACT_START, 1'b0, 16'd2, 16'd1);
    repeat (10) queue_cmd(ACT_TICK, 1'b0, 16'h0000, 16'h0000);
    queue_cmd(ACT_START, 1'b1, 16'd0, 16'd0);
    repeat (4) queue_cmd(ACT_TICK, 1'b1, 16'hffff, 16'hffff);
    queue_cmd(ACT_STOP, 1'b1, 16'hffff, 16'hffff);
    queue_cmd(ACT_START, 1'b0, 16'hffff, 16'hffff);
    repeat (2) queue_cmd(ACT_TICK, 1'b0, 16'h0000, 16'h0000);
    queue_cmd(ACT_STOP, 1'b0, 16'h0000, 16'h0000);
    settle();

    // Zero settings everywhere, plus a write to an unused index
    write_reg(CFG_INDEX_UNUSED, CFG_DATA_W'($urandom));
    program_tones(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_traffic(100);
    settle();

    // Largest settings; counts written with all data bits set
    program_tones(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    run_traffic(60);
    settle();

    // Random small settings; upper data bits of the counts are don't-care
    repeat (8) begin
      program_tones(CFG_DATA_W'($urandom_range(0, 5)), CFG_DATA_W'($urandom_range(0, 5)),
                    {8'($urandom), 8'($urandom_range(0, 4))},
                    CFG_DATA_W'($urandom_range(0, 5)), CFG_DATA_W'($urandom_range(0, 5)),
                    {8'($urandom), 8'($urandom_range(0, 4))});
      run_traffic(115);
      settle();
    end

    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
